### rtl/mts_pkg.sv
// shared types and constants for the min tracking stack
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  // storage geometry
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = 32;

  // operation codes
  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_read;
  } sts_t;

endpackage

`default_nettype wire

### rtl/mts_ctrl.sv
// sequencing state machine for the min tracking stack
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl
  import mts_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_READ   = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_read ? S_READ : S_RESULT;
      end
      S_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/mts_dp.sv
// stack memories, counters and top registers of the min tracking stack
`timescale 1ns / 1ps
`default_nettype none

module mts_dp
  import mts_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  wire  [1:0]           action_i,
  input  wire  signed [DW-1:0] push_value_i,
  output logic [1:0]           status_o,
  output logic signed [DW-1:0] popped_value_o,
  output logic signed [DW-1:0] top_value_o,
  output logic signed [DW-1:0] min_value_o,
  output logic                 is_empty_o,
  output logic [CW-1:0]        depth_used_o
);

  logic [DW-1:0] value_mem  [DEPTH];
  logic [DW-1:0] minima_mem [DEPTH];

  logic [CW-1:0] vc_q, vc_d, mc_q, mc_d;
  action_e       action_q;
  logic signed [DW-1:0] val_q, top_q, min_q, popped_q, popped_d;
  status_e       status_q, status_d;
  logic [DW-1:0] v_rd_q, m_rd_q;
  logic          wr_v, wr_m, to_min, full, empty;
  logic [CW-1:0] v_raddr_w, m_raddr_w;
  logic [AW-1:0] v_raddr, m_raddr;

  assign full  = (vc_q == CW'(DEPTH));
  assign empty = (vc_q == '0);
  assign to_min = (mc_q == '0) || (val_q <= min_q);

  // operation decode
  always_comb begin
    vc_d     = vc_q;
    mc_d     = mc_q;
    status_d = ST_OK;
    popped_d = '0;
    wr_v     = 1'b0;
    wr_m     = 1'b0;
    sts_o.need_read = 1'b0;
    case (action_q)
      ACT_PUSH: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          wr_v = 1'b1;
          vc_d = vc_q + CW'(1);
          if (to_min) begin
            wr_m = 1'b1;
            mc_d = mc_q + CW'(1);
          end
        end
      end
      ACT_POP: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          popped_d = top_q;
          vc_d     = vc_q - CW'(1);
          if (mc_q != '0 && min_q == top_q) begin
            mc_d = mc_q - CW'(1);
          end
          sts_o.need_read = 1'b1;
        end
      end
      ACT_CLEAR: begin
        vc_d = '0;
        mc_d = '0;
      end
      default: begin
      end
    endcase
  end

  // read addresses of the new tops after a pop
  assign v_raddr_w = vc_q - CW'(2);
  assign m_raddr_w = mc_d - CW'(1);
  assign v_raddr   = v_raddr_w[AW-1:0];
  assign m_raddr   = m_raddr_w[AW-1:0];

  // value stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_v) begin
      value_mem[vc_q[AW-1:0]] <= val_q;
    end
    v_rd_q <= value_mem[v_raddr];
  end

  // minima stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_m) begin
      minima_mem[mc_q[AW-1:0]] <= val_q;
    end
    m_rd_q <= minima_mem[m_raddr];
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= '0;
      mc_q <= '0;
    end else if (cmd_i.exec) begin
      vc_q <= vc_d;
      mc_q <= mc_d;
    end
  end

  // operand, top and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_e'(action_i);
      val_q    <= push_value_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      popped_q <= popped_d;
      if (wr_v) begin
        top_q <= val_q;
      end
      if (wr_m) begin
        min_q <= val_q;
      end
    end
    if (cmd_i.capture) begin
      top_q <= v_rd_q;
      min_q <= m_rd_q;
    end
  end

  // result fields
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign top_value_o    = empty ? '0 : top_q;
  assign min_value_o    = (empty || mc_q == '0) ? '0 : min_q;
  assign is_empty_o     = empty;
  assign depth_used_o   = vc_q;

endmodule

`default_nettype wire

### rtl/min_tracking_stack_top.sv
// top level of the min tracking stack
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o  | action_i, push_value_i
//   out     | output    | out_valid_o / out_ready_i| status_o, popped_value_o,
//           |           |                          | top_value_o, min_value_o,
//           |           |                          | is_empty_o, depth_used_o
//
// one transaction in flight: accept, execute, then hold the result
// push, clear and no-op pass execute then result, pop adds a read state:
// a pop reads the new tops from the single read port of each stack memory
// the result holds on the outputs while out_ready_i is low; no input is taken
// reset empties both stacks at once, memories need no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack_top
  import mts_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  [1:0]           action_i,
  input  wire  signed [DW-1:0] push_value_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [1:0]           status_o,
  output logic signed [DW-1:0] popped_value_o,
  output logic signed [DW-1:0] top_value_o,
  output logic signed [DW-1:0] min_value_o,
  output logic                 is_empty_o,
  output logic [CW-1:0]        depth_used_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // stacks and result logic
  mts_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .push_value_i   (push_value_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .top_value_o    (top_value_o),
    .min_value_o    (min_value_o),
    .is_empty_o     (is_empty_o),
    .depth_used_o   (depth_used_o)
  );

endmodule

`default_nettype wire
